@@ src/irpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg
// Types and constants shared by the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int TIME_WIDTH      = 24;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int FRAME_WIDTH     = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int INDEX_WIDTH     = 6;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MAX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_MIN   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_MAX   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_MIN  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_MAX  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAP_MIN   = 3'd6;

   // Reset values of the timing windows, in microseconds
   localparam logic [TIME_WIDTH-1:0] START_MIN_RESET = 24'd10000;
   localparam logic [TIME_WIDTH-1:0] START_MAX_RESET = 24'd15000;
   localparam logic [TIME_WIDTH-1:0] ONE_MIN_RESET   = 24'd2000;
   localparam logic [TIME_WIDTH-1:0] ONE_MAX_RESET   = 24'd2400;
   localparam logic [TIME_WIDTH-1:0] ZERO_MIN_RESET  = 24'd1000;
   localparam logic [TIME_WIDTH-1:0] ZERO_MAX_RESET  = 24'd1200;
   localparam logic [TIME_WIDTH-1:0] GAP_MIN_RESET   = 24'd20000;

   localparam logic [INDEX_WIDTH-1:0] INDEX_FULL     = 6'd32;
   localparam logic [INDEX_WIDTH-1:0] INDEX_OVERFLOW = 6'd33;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] start_min;
      logic [TIME_WIDTH-1:0] start_max;
      logic [TIME_WIDTH-1:0] one_min;
      logic [TIME_WIDTH-1:0] one_max;
      logic [TIME_WIDTH-1:0] zero_min;
      logic [TIME_WIDTH-1:0] zero_max;
      logic [TIME_WIDTH-1:0] gap_min;
   } cfg_type;

   typedef struct packed {
      logic is_start;
      logic is_one;
      logic is_zero;
      logic is_gap;
   } class_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  address;
      logic [BYTE_WIDTH-1:0]  address_inverted;
      logic [BYTE_WIDTH-1:0]  data;
      logic [BYTE_WIDTH-1:0]  data_inverted;
      logic                   frame_ok;
      logic [INDEX_WIDTH-1:0] bits_seen;
   } result_type;

endpackage

@@ src/irpd_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_csr
// Timing window registers, written over the csr channel.
// ----------------------------------------------------------------------------
module irpd_csr
   import irpd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [TIME_WIDTH-1:0]      wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_START_MIN: cfg_in.start_min = wr_data;
            CSR_START_MAX: cfg_in.start_max = wr_data;
            CSR_ONE_MIN:   cfg_in.one_min   = wr_data;
            CSR_ONE_MAX:   cfg_in.one_max   = wr_data;
            CSR_ZERO_MIN:  cfg_in.zero_min  = wr_data;
            CSR_ZERO_MAX:  cfg_in.zero_max  = wr_data;
            CSR_GAP_MIN:   cfg_in.gap_min   = wr_data;
            default: ;     // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_min <= START_MIN_RESET;
         cfg_ff.start_max <= START_MAX_RESET;
         cfg_ff.one_min   <= ONE_MIN_RESET;
         cfg_ff.one_max   <= ONE_MAX_RESET;
         cfg_ff.zero_min  <= ZERO_MIN_RESET;
         cfg_ff.zero_max  <= ZERO_MAX_RESET;
         cfg_ff.gap_min   <= GAP_MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/irpd_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_classify
// Sorts one interval into the start, one, zero and gap windows.
// ----------------------------------------------------------------------------
module irpd_classify
   import irpd_pkg::*;
(
   input  logic [TIME_WIDTH-1:0] interval,
   input  cfg_type               cfg,
   output class_type             cls
);

   // all window bounds are exclusive
   assign cls.is_start = (interval > cfg.start_min) && (interval < cfg.start_max);
   assign cls.is_one   = (interval > cfg.one_min)   && (interval < cfg.one_max);
   assign cls.is_zero  = (interval > cfg.zero_min)  && (interval < cfg.zero_max);
   assign cls.is_gap   = (interval > cfg.gap_min);

endmodule

@@ src/irpd_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_frame
// Frame state: receive flag, bit shift-in and end-of-frame result.
// ----------------------------------------------------------------------------
module irpd_frame
   import irpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  class_type  cls,
   output logic       emit,
   output result_type result
);

   logic                   receiving_ff, receiving_in;
   logic [FRAME_WIDTH-1:0] frame_bits_ff, frame_bits_in;
   logic [INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic                   store, store_one;

   // one window wins over zero, zero over gap
   assign store     = receiving_ff && (cls.is_one || cls.is_zero);
   assign store_one = cls.is_one;
   assign emit      = receiving_ff && !cls.is_one && !cls.is_zero && cls.is_gap;

   always_comb begin
      receiving_in  = receiving_ff;
      frame_bits_in = frame_bits_ff;
      bit_index_in  = bit_index_ff;
      if (step) begin
         if (!receiving_ff) begin
            if (cls.is_start) begin
               receiving_in = 1'b1;
               bit_index_in = '0;
            end
         end else if (store) begin
            if (bit_index_ff < INDEX_FULL) begin
               frame_bits_in[bit_index_ff[4:0]] = store_one;
               bit_index_in = bit_index_ff + 6'd1;
            end else begin
               bit_index_in = INDEX_OVERFLOW;
            end
         end else if (emit) begin
            receiving_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         frame_bits_ff <= '0;
         bit_index_ff  <= '0;
      end else begin
         receiving_ff  <= receiving_in;
         frame_bits_ff <= frame_bits_in;
         bit_index_ff  <= bit_index_in;
      end
   end

   assign result.address          = frame_bits_ff[7:0];
   assign result.address_inverted = frame_bits_ff[15:8];
   assign result.data             = frame_bits_ff[23:16];
   assign result.data_inverted    = frame_bits_ff[31:24];
   assign result.frame_ok = ((frame_bits_ff[7:0] & frame_bits_ff[15:8]) |
                             (frame_bits_ff[23:16] & frame_bits_ff[31:24])) == 8'd0;
   assign result.bits_seen        = bit_index_ff;

endmodule

@@ src/ir_pulse_distance_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance IR remote frame decoder: edge intervals in, frames out.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  req     | valid / stall      | interval_us[23:0]
//  rsp     | valid / stall      | address, address_inverted, data,
//          |                    | data_inverted, frame_ok, bits_seen
//  csr     | valid / ready      | index[2:0], wdata[23:0]
//
//  One interval per cycle while req is not stalled; each beat is registered in the
//  input register, and a beat that closes a frame registers its result for rsp.
//  The input only stalls while a finished frame waits and rsp is stalled.
//  Reset is synchronous; windows return to their defaults, no clearing pass.
//  csr_ready is always high.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder
   import irpd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [TIME_WIDTH-1:0]      req_interval_us,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BYTE_WIDTH-1:0]      rsp_address,
   output logic [BYTE_WIDTH-1:0]      rsp_address_inverted,
   output logic [BYTE_WIDTH-1:0]      rsp_data,
   output logic [BYTE_WIDTH-1:0]      rsp_data_inverted,
   output logic                       rsp_frame_ok,
   output logic [INDEX_WIDTH-1:0]     rsp_bits_seen,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]      csr_wdata
);

   cfg_type    cfg;
   class_type  cls;
   result_type result, result_ff;
   logic       emit, advance, req_take, rsp_take;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [TIME_WIDTH-1:0] interval_ff;

   assign csr_ready = 1'b1;

   irpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   irpd_classify u_classify (
      .interval (interval_ff),
      .cfg      (cfg),
      .cls      (cls)
   );

   irpd_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cls    (cls),
      .emit   (emit),
      .result (result)
   );

   // held beat moves on unless it closes a frame and the result slot is blocked
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = (advance && emit) ? 1'b1 : (rsp_take ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         interval_ff <= req_interval_us;
      end
      if (advance && emit) begin
         result_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_address          = result_ff.address;
   assign rsp_address_inverted = result_ff.address_inverted;
   assign rsp_data             = result_ff.data;
   assign rsp_data_inverted    = result_ff.data_inverted;
   assign rsp_frame_ok         = result_ff.frame_ok;
   assign rsp_bits_seen        = result_ff.bits_seen;

endmodule

@@ src/irpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module irpd_checker
   import irpd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [BYTE_WIDTH-1:0]  rsp_address,
   input logic [BYTE_WIDTH-1:0]  rsp_address_inverted,
   input logic [BYTE_WIDTH-1:0]  rsp_data,
   input logic [BYTE_WIDTH-1:0]  rsp_data_inverted,
   input logic                   rsp_frame_ok,
   input logic [INDEX_WIDTH-1:0] rsp_bits_seen
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_address) &&
         $stable(rsp_data) && $stable(rsp_bits_seen))
      else $error("stalled result beat changed");

   // check flag agrees with the bytes it covers
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_ok ==
         (((rsp_address & rsp_address_inverted) |
           (rsp_data & rsp_data_inverted)) == 8'd0))
      else $error("frame_ok inconsistent with frame bytes");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bits_seen <= INDEX_OVERFLOW)
      else $error("bits_seen beyond overflow code");

   // a fresh result follows a taken input beat; a held beat
   // only waits behind a result that is still valid
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a preceding input beat");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind ir_pulse_distance_frame_decoder irpd_checker u_irpd_checker (.*);
